// ----- rtl/core/bcdrtc_pkg.sv -----
// Shared types, register map codes and constant tables for the BCD RTC block.
// Used by the channel interfaces, the time keeper, the interval timer and the top level.
// No dependencies.
package bcdrtc_pkg;

   // Payload widths
   localparam int OP_W    = 2;
   localparam int NIBBLE_W = 4;
   localparam int COUNT_W = 10;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Register map
   localparam logic [3:0] ADDR_STATUS  = 4'h0;
   localparam logic [3:0] ADDR_TENTHS  = 4'h1;
   localparam logic [3:0] ADDR_SEC_U   = 4'h2;
   localparam logic [3:0] ADDR_SEC_T   = 4'h3;
   localparam logic [3:0] ADDR_MIN_U   = 4'h4;
   localparam logic [3:0] ADDR_MIN_T   = 4'h5;
   localparam logic [3:0] ADDR_HR_U    = 4'h6;
   localparam logic [3:0] ADDR_HR_T    = 4'h7;
   localparam logic [3:0] ADDR_DAY_U   = 4'h8;
   localparam logic [3:0] ADDR_DAY_T   = 4'h9;
   localparam logic [3:0] ADDR_MON_U   = 4'hA;
   localparam logic [3:0] ADDR_MON_T   = 4'hB;
   localparam logic [3:0] ADDR_YR_U    = 4'hC;
   localparam logic [3:0] ADDR_YR_T    = 4'hD;
   localparam logic [3:0] ADDR_WDAY    = 4'hE;
   localparam logic [3:0] ADDR_SETTING = 4'hF;

   // Control register bits
   localparam int CTRL_HOLD_BIT    = 0;  // interrupt timer held
   localparam int CTRL_IRQ_SEL_BIT = 1;  // address F maps to interrupt control
   localparam int CTRL_STOP_BIT    = 2;  // clock stopped

   // Status register bits
   localparam int STAT_IRQ_BIT     = 0;
   localparam int STAT_CHANGED_BIT = 3;

   // Clock setting bits
   localparam int SET_24H_BIT = 0;
   localparam int SET_PM_BIT  = 1;

   // Interrupt control bits
   localparam int IC_REPEAT_BIT = 3;

   // Days per month, January first
   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Command to the time keeper for one request
   typedef struct packed {
      logic                tick;        // tick with clock running
      logic                wr_en;       // bus write, digit registers
      logic                wr_setting;  // bus write of clock setting
      logic                clr_tenths;  // control write with stop bit set
      logic [3:0]          addr;
      logic [NIBBLE_W-1:0] data;
   } time_cmd_type;

   // Command to the interval timer for one request
   typedef struct packed {
      logic                tick;
      logic                wr_ctrl;      // bus write of control register
      logic                wr_irq_ctrl;  // bus write of interrupt control
      logic                hold;         // control hold bit before the write
      logic [NIBBLE_W-1:0] data;
   } timer_cmd_type;

   // Delay in ticks for an interrupt delay code; zero means off
   function automatic logic [COUNT_W-1:0] delay_ticks(input logic [2:0] code);
      logic [COUNT_W-1:0] n;
      case (code)
         3'd1:    n = 10'd1;
         3'd2:    n = 10'd5;
         3'd3:    n = 10'd10;
         3'd4:    n = 10'd50;
         3'd5:    n = 10'd100;
         3'd6:    n = 10'd300;
         3'd7:    n = 10'd600;
         default: n = 10'd0;
      endcase
      return n;
   endfunction

   // Length of a month; out-of-range months get 31 days
   function automatic logic [4:0] month_days(input logic [7:0] month, input logic leap);
      logic [4:0] n;
      if (month == 8'd2 && leap) begin
         n = 5'd29;
      end else if (month >= 8'd1 && month <= 8'd12) begin
         n = MONTH_LEN[4'(month[3:0] - 4'd1)];
      end else begin
         n = 5'd31;
      end
      return n;
   endfunction

   // Binary value of a two-digit field (digits may be non-BCD)
   function automatic logic [7:0] two_digit(input logic [3:0] tens, input logic [3:0] units);
      return 8'(tens) * 8'd10 + 8'(units);
   endfunction

endpackage

// ----- rtl/core/bcdrtc_if.sv -----
// Valid/ready channel interfaces for BCD RTC requests and results.
// Depends on bcdrtc_pkg for payload widths.
interface bcdrtc_req_if;
   logic                             valid;
   logic                             ready;
   logic [bcdrtc_pkg::OP_W-1:0]      operation;
   logic [3:0]                       address;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]  write_data;

   modport source (output valid, operation, address, write_data, input ready);
   modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface bcdrtc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]  read_data;
   logic                             irq_pending;

   modport source (output valid, read_data, irq_pending, input ready);
   modport sink   (input valid, read_data, irq_pending, output ready);
endinterface

// ----- rtl/core/bcdrtc_time.sv -----
// Time keeper: BCD time/date digits, weekday and clock setting, with tick ripple.
// Depends on bcdrtc_pkg.
module bcdrtc_time (
   input  logic                             clock,
   input  logic                             reset,
   input  bcdrtc_pkg::time_cmd_type         cmd,
   output logic [bcdrtc_pkg::NIBBLE_W-1:0]  rd_data
);

   localparam logic [3:0] DEC_LIMIT  = 4'd10;
   localparam logic [3:0] SEXA_LIMIT = 4'd6;
   localparam logic [3:0] WDAY_LIMIT = 4'd8;

   logic [3:0] tenths_ff, sec_u_ff, sec_t_ff, min_u_ff, min_t_ff, hr_u_ff, hr_t_ff;
   logic [3:0] day_u_ff, day_t_ff, mon_u_ff, mon_t_ff, yr_u_ff, yr_t_ff, wday_ff, setting_ff;
   logic [3:0] tenths_in, sec_u_in, sec_t_in, min_u_in, min_t_in, hr_u_in, hr_t_in;
   logic [3:0] day_u_in, day_t_in, mon_u_in, mon_t_in, yr_u_in, yr_t_in, wday_in, setting_in;

   // Increment a 4-bit digit; carry and clear when it reaches the limit
   function automatic logic [4:0] bump(input logic [3:0] d, input logic [3:0] limit);
      logic [3:0] n;
      n = 4'(d + 4'd1);
      return (n == limit) ? 5'b1_0000 : {1'b0, n};
   endfunction

   // Tick ripple and bus writes
   always_comb begin : next_state
      logic [4:0] step;
      logic       carry;
      logic       h24;
      logic       day_adv;
      logic [7:0] hv;
      logic [4:0] dim;

      tenths_in  = tenths_ff;  sec_u_in = sec_u_ff;  sec_t_in = sec_t_ff;
      min_u_in   = min_u_ff;   min_t_in = min_t_ff;  hr_u_in  = hr_u_ff;
      hr_t_in    = hr_t_ff;    day_u_in = day_u_ff;  day_t_in = day_t_ff;
      mon_u_in   = mon_u_ff;   mon_t_in = mon_t_ff;  yr_u_in  = yr_u_ff;
      yr_t_in    = yr_t_ff;    wday_in  = wday_ff;   setting_in = setting_ff;
      h24     = setting_ff[bcdrtc_pkg::SET_24H_BIT];
      day_adv = 1'b0;
      hv      = '0;
      dim     = '0;
      carry   = 1'b0;
      step    = '0;

      if (cmd.tick) begin
         // seconds and minutes carry chain
         step = bump(tenths_ff, DEC_LIMIT);
         tenths_in = step[3:0];
         carry = step[4];
         if (carry) begin
            step = bump(sec_u_ff, DEC_LIMIT);
            sec_u_in = step[3:0];
            carry = step[4];
         end
         if (carry) begin
            step = bump(sec_t_ff, SEXA_LIMIT);
            sec_t_in = step[3:0];
            carry = step[4];
         end
         if (carry) begin
            step = bump(min_u_ff, DEC_LIMIT);
            min_u_in = step[3:0];
            carry = step[4];
         end
         if (carry) begin
            step = bump(min_t_ff, SEXA_LIMIT);
            min_t_in = step[3:0];
            carry = step[4];
         end

         // hours with 12/24-hour wrap
         if (carry) begin
            step = bump(hr_u_ff, DEC_LIMIT);
            hr_u_in = step[3:0];
            if (step[4]) begin
               hr_t_in = 4'(hr_t_ff + 4'd1);
            end
            hv = bcdrtc_pkg::two_digit(hr_t_in, hr_u_in);
            if (!h24 && hv == 8'd12) begin
               setting_in[bcdrtc_pkg::SET_PM_BIT] = ~setting_ff[bcdrtc_pkg::SET_PM_BIT];
            end
            if (!h24 && hv == 8'd13) begin
               hr_t_in = 4'd0;
               hr_u_in = 4'd1;
            end
            if (h24 && hv == 8'd24) begin
               hr_t_in = 4'd0;
               hr_u_in = 4'd0;
            end
            hv = bcdrtc_pkg::two_digit(hr_t_in, hr_u_in);
            day_adv = h24 ? (hv == 8'd0)
                          : (hv == 8'd12 && !setting_in[bcdrtc_pkg::SET_PM_BIT]);
         end

         // day, weekday, month, leap counter, year
         if (day_adv) begin
            step = bump(day_u_ff, DEC_LIMIT);
            day_u_in = step[3:0];
            if (step[4]) begin
               day_t_in = 4'(day_t_ff + 4'd1);
            end
            step = bump(wday_ff, WDAY_LIMIT);
            wday_in = step[4] ? 4'd1 : step[3:0];
            dim = bcdrtc_pkg::month_days(bcdrtc_pkg::two_digit(mon_t_ff, mon_u_ff),
                                         setting_in[3:2] == 2'd0);
            if (bcdrtc_pkg::two_digit(day_t_in, day_u_in) == 8'(dim) + 8'd1) begin
               day_t_in = 4'd0;
               day_u_in = 4'd1;
               step = bump(mon_u_ff, DEC_LIMIT);
               mon_u_in = step[3:0];
               if (step[4]) begin
                  mon_t_in = 4'(mon_t_ff + 4'd1);
               end
               if (bcdrtc_pkg::two_digit(mon_t_in, mon_u_in) == 8'd13) begin
                  mon_t_in = 4'd0;
                  mon_u_in = 4'd1;
                  setting_in[3:2] = 2'(setting_in[3:2] + 2'd1);
                  step = bump(yr_u_ff, DEC_LIMIT);
                  yr_u_in = step[3:0];
                  if (step[4]) begin
                     step = bump(yr_t_ff, DEC_LIMIT);
                     yr_t_in = step[3:0];
                  end
               end
            end
         end
      end

      // bus writes
      if (cmd.clr_tenths) begin
         tenths_in = 4'd0;
      end
      if (cmd.wr_setting) begin
         setting_in = cmd.data;
      end
      if (cmd.wr_en) begin
         case (cmd.addr)
            bcdrtc_pkg::ADDR_SEC_U: sec_u_in = cmd.data;
            bcdrtc_pkg::ADDR_SEC_T: sec_t_in = cmd.data;
            bcdrtc_pkg::ADDR_MIN_U: min_u_in = cmd.data;
            bcdrtc_pkg::ADDR_MIN_T: min_t_in = cmd.data;
            bcdrtc_pkg::ADDR_HR_U:  hr_u_in  = cmd.data;
            bcdrtc_pkg::ADDR_HR_T:  hr_t_in  = cmd.data;
            bcdrtc_pkg::ADDR_DAY_U: day_u_in = cmd.data;
            bcdrtc_pkg::ADDR_DAY_T: day_t_in = cmd.data;
            bcdrtc_pkg::ADDR_MON_U: mon_u_in = cmd.data;
            bcdrtc_pkg::ADDR_MON_T: mon_t_in = cmd.data;
            bcdrtc_pkg::ADDR_YR_U:  yr_u_in  = cmd.data;
            bcdrtc_pkg::ADDR_YR_T:  yr_t_in  = cmd.data;
            bcdrtc_pkg::ADDR_WDAY:  wday_in  = cmd.data;
            default: ;
         endcase
      end
   end

   // Read mux; status and interrupt control live elsewhere
   always_comb begin
      case (cmd.addr)
         bcdrtc_pkg::ADDR_TENTHS:  rd_data = tenths_ff;
         bcdrtc_pkg::ADDR_SEC_U:   rd_data = sec_u_ff;
         bcdrtc_pkg::ADDR_SEC_T:   rd_data = sec_t_ff;
         bcdrtc_pkg::ADDR_MIN_U:   rd_data = min_u_ff;
         bcdrtc_pkg::ADDR_MIN_T:   rd_data = min_t_ff;
         bcdrtc_pkg::ADDR_HR_U:    rd_data = hr_u_ff;
         bcdrtc_pkg::ADDR_HR_T:    rd_data = hr_t_ff;
         bcdrtc_pkg::ADDR_DAY_U:   rd_data = day_u_ff;
         bcdrtc_pkg::ADDR_DAY_T:   rd_data = day_t_ff;
         bcdrtc_pkg::ADDR_MON_U:   rd_data = mon_u_ff;
         bcdrtc_pkg::ADDR_MON_T:   rd_data = mon_t_ff;
         bcdrtc_pkg::ADDR_YR_U:    rd_data = yr_u_ff;
         bcdrtc_pkg::ADDR_YR_T:    rd_data = yr_t_ff;
         bcdrtc_pkg::ADDR_WDAY:    rd_data = wday_ff;
         // PM bit reads as zero in 24-hour mode
         bcdrtc_pkg::ADDR_SETTING: rd_data = setting_ff[bcdrtc_pkg::SET_24H_BIT]
                                             ? (setting_ff & 4'hD) : setting_ff;
         default:                  rd_data = 4'd0;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tenths_ff <= 4'd0;  sec_u_ff <= 4'd0;  sec_t_ff <= 4'd0;
         min_u_ff  <= 4'd0;  min_t_ff <= 4'd0;  hr_u_ff  <= 4'd0;
         hr_t_ff   <= 4'd0;  day_u_ff <= 4'd1;  day_t_ff <= 4'd0;
         mon_u_ff  <= 4'd1;  mon_t_ff <= 4'd0;  yr_u_ff  <= 4'd0;
         yr_t_ff   <= 4'd0;  wday_ff  <= 4'd1;  setting_ff <= 4'd1;
      end else begin
         tenths_ff <= tenths_in;  sec_u_ff <= sec_u_in;  sec_t_ff <= sec_t_in;
         min_u_ff  <= min_u_in;   min_t_ff <= min_t_in;  hr_u_ff  <= hr_u_in;
         hr_t_ff   <= hr_t_in;    day_u_ff <= day_u_in;  day_t_ff <= day_t_in;
         mon_u_ff  <= mon_u_in;   mon_t_ff <= mon_t_in;  yr_u_ff  <= yr_u_in;
         yr_t_ff   <= yr_t_in;    wday_ff  <= wday_in;   setting_ff <= setting_in;
      end
   end

endmodule

// ----- rtl/core/bcdrtc_timer.sv -----
// Interval timer: interrupt control register, tick countdown and arming logic.
// Depends on bcdrtc_pkg.
module bcdrtc_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  bcdrtc_pkg::timer_cmd_type        cmd,
   output logic                             expire,
   output logic [bcdrtc_pkg::NIBBLE_W-1:0]  irq_ctrl
);

   logic [bcdrtc_pkg::NIBBLE_W-1:0] irq_ctrl_ff, irq_ctrl_in;
   logic [bcdrtc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                            armed_ff, armed_in;

   assign irq_ctrl = irq_ctrl_ff;

   // Arming, disarming and countdown
   always_comb begin : next_state
      logic [bcdrtc_pkg::COUNT_W-1:0] load;
      logic [bcdrtc_pkg::COUNT_W-1:0] dec;

      irq_ctrl_in = irq_ctrl_ff;
      count_in    = count_ff;
      armed_in    = armed_ff;
      expire      = 1'b0;
      load        = bcdrtc_pkg::delay_ticks(irq_ctrl_ff[2:0]);
      dec         = count_ff - 10'd1;

      // control write: setting hold disarms, releasing it rearms
      if (cmd.wr_ctrl) begin
         if (!cmd.hold && cmd.data[bcdrtc_pkg::CTRL_HOLD_BIT]) begin
            armed_in = 1'b0;
         end else if (cmd.hold && !cmd.data[bcdrtc_pkg::CTRL_HOLD_BIT]) begin
            count_in = load;
            armed_in = (load != '0);
         end
      end

      // interrupt control write rearms with the new delay unless held
      if (cmd.wr_irq_ctrl) begin
         irq_ctrl_in = cmd.data;
         if (!cmd.hold) begin
            count_in = bcdrtc_pkg::delay_ticks(cmd.data[2:0]);
            armed_in = (count_in != '0);
         end
      end

      // countdown, expiry and optional reload
      if (cmd.tick && armed_ff) begin
         count_in = dec;
         if (dec == '0) begin
            expire = 1'b1;
            if (irq_ctrl_ff[bcdrtc_pkg::IC_REPEAT_BIT]) begin
               count_in = load;
               armed_in = (load != '0);
            end else begin
               armed_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_ctrl_ff <= '0;
         count_ff    <= '0;
         armed_ff    <= 1'b0;
      end else begin
         irq_ctrl_ff <= irq_ctrl_in;
         count_ff    <= count_in;
         armed_ff    <= armed_in;
      end
   end

endmodule

// ----- rtl/core/bcd_rtc_calendar_registers.sv -----
// BCD real-time clock/calendar register block: top level with request and result stages.
// Depends on bcdrtc_pkg, bcdrtc_req_if/bcdrtc_rsp_if, bcdrtc_time and bcdrtc_timer.
//
// Sixteen 4-bit registers of a BCD clock/calendar with an interval-timer interrupt.
// Each request is a bus read, a bus write or a tenth-second tick, and returns exactly
// one result carrying the read nibble (zero for writes and ticks) and the interrupt
// flag after the request. The block takes one request per clock while results are
// taken: a request is held in an input register, and its whole effect (BCD carry
// ripple through time and date, timer countdown, register read and write) is applied
// as it moves into the result register, which presents the result. While a result
// waits to be taken, the input register takes one more request and then holds the
// input off. Reading address 0 returns status and clears it.
module bcd_rtc_calendar_registers (
   input  logic         clock,
   input  logic         reset,
   bcdrtc_req_if.sink   req_ch,
   bcdrtc_rsp_if.source rsp_ch
);

   // Input stage
   logic                              s1_valid_ff;
   logic [bcdrtc_pkg::OP_W-1:0]       s1_op_ff;
   logic [3:0]                        s1_addr_ff;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]   s1_data_ff;

   // Result stage
   logic                              rsp_valid_ff;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              rsp_irq_ff;

   // Control and status
   logic [bcdrtc_pkg::NIBBLE_W-1:0]   control_ff, control_in;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]   status_ff, status_in;

   logic                              out_free, s1_go;
   logic                              is_read, is_write, is_tick, stopped;
   logic                              irq_sel;
   bcdrtc_pkg::time_cmd_type          time_cmd;
   bcdrtc_pkg::timer_cmd_type         timer_cmd;
   logic [bcdrtc_pkg::NIBBLE_W-1:0]   time_rd, irq_ctrl;
   logic                              expire;

   // Handshake
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.irq_pending = rsp_irq_ff;

   // Request decode
   assign is_read  = s1_go && (s1_op_ff == bcdrtc_pkg::OP_READ);
   assign is_write = s1_go && (s1_op_ff == bcdrtc_pkg::OP_WRITE);
   assign is_tick  = s1_go && (s1_op_ff == bcdrtc_pkg::OP_TICK);
   assign stopped  = control_ff[bcdrtc_pkg::CTRL_STOP_BIT];
   assign irq_sel  = control_ff[bcdrtc_pkg::CTRL_IRQ_SEL_BIT];

   // Commands to the time keeper and the timer
   always_comb begin
      time_cmd.tick       = is_tick && !stopped;
      time_cmd.wr_en      = is_write;
      time_cmd.wr_setting = is_write && (s1_addr_ff == bcdrtc_pkg::ADDR_SETTING) && !irq_sel;
      time_cmd.clr_tenths = is_write && (s1_addr_ff == bcdrtc_pkg::ADDR_STATUS)
                            && s1_data_ff[bcdrtc_pkg::CTRL_STOP_BIT];
      time_cmd.addr       = s1_addr_ff;
      time_cmd.data       = s1_data_ff;

      timer_cmd.tick        = is_tick;
      timer_cmd.wr_ctrl     = is_write && (s1_addr_ff == bcdrtc_pkg::ADDR_STATUS);
      timer_cmd.wr_irq_ctrl = is_write && (s1_addr_ff == bcdrtc_pkg::ADDR_SETTING) && irq_sel;
      timer_cmd.hold        = control_ff[bcdrtc_pkg::CTRL_HOLD_BIT];
      timer_cmd.data        = s1_data_ff;
   end

   bcdrtc_time u_time (
      .clock   (clock),
      .reset   (reset),
      .cmd     (time_cmd),
      .rd_data (time_rd)
   );

   bcdrtc_timer u_timer (
      .clock    (clock),
      .reset    (reset),
      .cmd      (timer_cmd),
      .expire   (expire),
      .irq_ctrl (irq_ctrl)
   );

   // Control, status and read data
   always_comb begin
      control_in  = control_ff;
      status_in   = status_ff;
      rsp_data_in = 4'd0;
      if (timer_cmd.wr_ctrl) begin
         control_in = s1_data_ff;
      end
      if (is_read) begin
         if (s1_addr_ff == bcdrtc_pkg::ADDR_STATUS) begin
            rsp_data_in = status_ff;
            status_in   = 4'd0;
         end else if (s1_addr_ff == bcdrtc_pkg::ADDR_SETTING && irq_sel) begin
            rsp_data_in = irq_ctrl;
         end else begin
            rsp_data_in = time_rd;
         end
      end
      if (time_cmd.tick) begin
         status_in[bcdrtc_pkg::STAT_CHANGED_BIT] = 1'b1;
      end
      if (expire) begin
         status_in[bcdrtc_pkg::STAT_IRQ_BIT] = 1'b1;
      end
   end

   // Control registers of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         control_ff   <= '0;
         status_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         control_ff <= control_in;
         status_ff  <= status_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_op_ff   <= req_ch.operation;
         s1_addr_ff <= req_ch.address;
         s1_data_ff <= req_ch.write_data;
      end
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= status_in[bcdrtc_pkg::STAT_IRQ_BIT];
      end
   end

   // A status read always reports the interrupt flag cleared
   a_status_read_clears: assert property (@(posedge clock) disable iff (reset)
      (is_read && s1_addr_ff == bcdrtc_pkg::ADDR_STATUS) |=> !rsp_ch.irq_pending)
      else $error("status read did not clear the interrupt flag");

   // Writes, ticks and unused codes return zero read data
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_op_ff != bcdrtc_pkg::OP_READ) |=> (rsp_ch.read_data == 4'd0))
      else $error("non-read request returned nonzero read data");

   // Input stalls only when both stages are full and the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a full pipeline");

   // A stopped clock never raises the data-changed flag
   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      (stopped && !status_ff[bcdrtc_pkg::STAT_CHANGED_BIT])
      |=> !status_ff[bcdrtc_pkg::STAT_CHANGED_BIT])
      else $error("data-changed flag set while clock stopped");

endmodule

// ----- tb/bcdrtc_checker.sv -----
// Scoreboard for the BCD RTC register block: watches both channels, predicts each result.
// Depends on bcdrtc_pkg for operation codes, register addresses and bit positions.
module bcdrtc_checker
   import bcdrtc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [3:0]          req_address,
   input  logic [NIBBLE_W-1:0] req_write_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [NIBBLE_W-1:0] rsp_read_data,
   input  logic                rsp_irq_pending,
   output int                  fail_count,
   output int                  pending_count,
   output int                  checked_count,
   output int                  irq_count
);

   typedef struct packed {
      logic [NIBBLE_W-1:0] read_data;
      logic                irq_pending;
   } rtc_result_type;

   rtc_result_type expected_q [$];
   int             fails;
   int             checked;
   int             irqs;

   // Predicted register file
   logic [3:0] stat_r, ctrl_r, setting_r, irq_ctl_r, wday_r, tenths_r;
   logic [3:0] sec_u, sec_t, min_u, min_t, hr_u, hr_t;
   logic [3:0] day_u, day_t, mon_u, mon_t, yr_u, yr_t;
   logic [COUNT_W-1:0] countdown;
   logic               armed;

   // Increment a 4-bit digit; wrap to zero and report a carry when it hits the limit
   function automatic logic step_digit(inout logic [3:0] d, input logic [3:0] lim);
      d = d + 4'd1;
      if (d == lim) begin
         d = 4'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_model();
      stat_r    = 4'd0;
      ctrl_r    = 4'd0;
      setting_r = 4'd1;
      irq_ctl_r = 4'd0;
      wday_r    = 4'd1;
      tenths_r  = 4'd0;
      {sec_t, sec_u, min_t, min_u, hr_t, hr_u} = '0;
      day_t = 4'd0;  day_u = 4'd1;
      mon_t = 4'd0;  mon_u = 4'd1;
      yr_t  = 4'd0;  yr_u  = 4'd0;
      countdown = '0;
      armed     = 1'b0;
   endtask

   // Load the countdown from the current delay code
   task automatic load_timer();
      logic [COUNT_W-1:0] n;
      case (irq_ctl_r[2:0])
         3'd1:    n = 10'd1;
         3'd2:    n = 10'd5;
         3'd3:    n = 10'd10;
         3'd4:    n = 10'd50;
         3'd5:    n = 10'd100;
         3'd6:    n = 10'd300;
         3'd7:    n = 10'd600;
         default: n = 10'd0;
      endcase
      countdown = n;
      armed     = (n != 10'd0);
   endtask

   // Day rollover: weekday, month length, month and year carry, leap counter
   task automatic next_day();
      int month;
      int last_day;
      if (step_digit(day_u, 4'd10)) day_t = day_t + 4'd1;
      if (step_digit(wday_r, 4'd8)) wday_r = 4'd1;
      month = int'(mon_t) * 10 + int'(mon_u);
      if (month == 2 && setting_r[3:2] == 2'd0) begin
         last_day = 29;
      end else begin
         case (month)
            2:             last_day = 28;
            4, 6, 9, 11:   last_day = 30;
            default:       last_day = 31;
         endcase
      end
      if (int'(day_t) * 10 + int'(day_u) != last_day + 1) return;
      day_t = 4'd0;
      day_u = 4'd1;
      if (step_digit(mon_u, 4'd10)) mon_t = mon_t + 4'd1;
      if (int'(mon_t) * 10 + int'(mon_u) != 13) return;
      mon_t = 4'd0;
      mon_u = 4'd1;
      setting_r[3:2] = setting_r[3:2] + 2'd1;
      if (step_digit(yr_u, 4'd10)) void'(step_digit(yr_t, 4'd10));
   endtask

   // Time and date ripple for one tick
   task automatic clock_step();
      logic h24;
      int   hour;
      if (ctrl_r[CTRL_STOP_BIT]) return;
      stat_r[STAT_CHANGED_BIT] = 1'b1;
      if (!step_digit(tenths_r, 4'd10)) return;
      if (!step_digit(sec_u, 4'd10)) return;
      if (!step_digit(sec_t, 4'd6)) return;
      if (!step_digit(min_u, 4'd10)) return;
      if (!step_digit(min_t, 4'd6)) return;
      if (step_digit(hr_u, 4'd10)) hr_t = hr_t + 4'd1;
      h24  = setting_r[SET_24H_BIT];
      hour = int'(hr_t) * 10 + int'(hr_u);
      if (!h24 && hour == 12) setting_r[SET_PM_BIT] = ~setting_r[SET_PM_BIT];
      if (!h24 && hour == 13) begin
         hr_t = 4'd0;
         hr_u = 4'd1;
      end
      if (h24 && hour == 24) begin
         hr_t = 4'd0;
         hr_u = 4'd0;
      end
      hour = int'(hr_t) * 10 + int'(hr_u);
      if (h24 ? (hour == 0) : (hour == 12 && !setting_r[SET_PM_BIT])) next_day();
   endtask

   // Interval timer for one tick
   task automatic timer_step();
      if (!armed) return;
      countdown = countdown - 10'd1;
      if (countdown != 10'd0) return;
      stat_r[STAT_IRQ_BIT] = 1'b1;
      if (irq_ctl_r[IC_REPEAT_BIT]) load_timer();
      else armed = 1'b0;
   endtask

   task automatic bus_read(input logic [3:0] a, output logic [3:0] r);
      case (a)
         ADDR_STATUS: begin
            r      = stat_r;
            stat_r = 4'd0;
         end
         ADDR_TENTHS: r = tenths_r;
         ADDR_SEC_U:  r = sec_u;
         ADDR_SEC_T:  r = sec_t;
         ADDR_MIN_U:  r = min_u;
         ADDR_MIN_T:  r = min_t;
         ADDR_HR_U:   r = hr_u;
         ADDR_HR_T:   r = hr_t;
         ADDR_DAY_U:  r = day_u;
         ADDR_DAY_T:  r = day_t;
         ADDR_MON_U:  r = mon_u;
         ADDR_MON_T:  r = mon_t;
         ADDR_YR_U:   r = yr_u;
         ADDR_YR_T:   r = yr_t;
         ADDR_WDAY:   r = wday_r;
         default: begin
            // PM bit is hidden in 24-hour mode
            if (ctrl_r[CTRL_IRQ_SEL_BIT]) r = irq_ctl_r;
            else if (setting_r[SET_24H_BIT]) r = setting_r & 4'hD;
            else r = setting_r;
         end
      endcase
   endtask

   task automatic bus_write(input logic [3:0] a, input logic [3:0] d);
      case (a)
         ADDR_STATUS: begin
            if (!ctrl_r[CTRL_HOLD_BIT] && d[CTRL_HOLD_BIT]) armed = 1'b0;
            else if (ctrl_r[CTRL_HOLD_BIT] && !d[CTRL_HOLD_BIT]) load_timer();
            if (d[CTRL_STOP_BIT]) tenths_r = 4'd0;
            ctrl_r = d;
         end
         ADDR_SETTING: begin
            if (ctrl_r[CTRL_IRQ_SEL_BIT]) begin
               irq_ctl_r = d;
               if (!ctrl_r[CTRL_HOLD_BIT]) load_timer();
            end else begin
               setting_r = d;
            end
         end
         ADDR_SEC_U: sec_u  = d;
         ADDR_SEC_T: sec_t  = d;
         ADDR_MIN_U: min_u  = d;
         ADDR_MIN_T: min_t  = d;
         ADDR_HR_U:  hr_u   = d;
         ADDR_HR_T:  hr_t   = d;
         ADDR_DAY_U: day_u  = d;
         ADDR_DAY_T: day_t  = d;
         ADDR_MON_U: mon_u  = d;
         ADDR_MON_T: mon_t  = d;
         ADDR_YR_U:  yr_u   = d;
         ADDR_YR_T:  yr_t   = d;
         ADDR_WDAY:  wday_r = d;
         default: ;  // tenths is read only
      endcase
   endtask

   task automatic predict_request(input logic [OP_W-1:0] op, input logic [3:0] a,
                                  input logic [3:0] d, output rtc_result_type res);
      logic [3:0] r;
      r = 4'd0;
      case (op)
         OP_READ:  bus_read(a, r);
         OP_WRITE: bus_write(a, d);
         OP_TICK: begin
            clock_step();
            timer_step();
         end
         default: ;  // unused code changes nothing
      endcase
      res.read_data   = r;
      res.irq_pending = stat_r[STAT_IRQ_BIT];
   endtask

   // Predict on accepted requests, compare on accepted results
   always @(posedge clock) begin : monitor
      rtc_result_type pred;
      rtc_result_type want;
      if (reset) begin
         clear_model();
         expected_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_operation, req_address, req_write_data, pred);
            expected_q.push_back(pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: read_data %h irq_pending %b",
                      rsp_read_data, rsp_irq_pending);
               fails++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  fails++;
               end
               if (rsp_irq_pending !== want.irq_pending) begin
                  $error("irq_pending: expected %b, got %b",
                         want.irq_pending, rsp_irq_pending);
                  fails++;
               end
               checked++;
               if (want.irq_pending) irqs++;
            end
         end
      end
      fail_count    <= fails;
      pending_count <= expected_q.size();
      checked_count <= checked;
      irq_count     <= irqs;
   end

endmodule

// ----- tb/tb_bcd_rtc_calendar_registers.sv -----
// Testbench top for the BCD RTC register block: clock, reset, request stimulus, verdict.
// Depends on bcdrtc_pkg, the channel interfaces, the block itself and bcdrtc_checker.
module tb_bcd_rtc_calendar_registers;
   import bcdrtc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 262;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;

   bcdrtc_req_if req_ch ();
   bcdrtc_rsp_if rsp_ch ();

   int fail_count, pending_count, checked_count, irq_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   int n_read = 0, n_write = 0, n_tick = 0, n_unused = 0;

   bcd_rtc_calendar_registers dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bcdrtc_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_operation   (req_ch.operation),
      .req_address     (req_ch.address),
      .req_write_data  (req_ch.write_data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_read_data   (rsp_ch.read_data),
      .rsp_irq_pending (rsp_ch.irq_pending),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .irq_count       (irq_count)
   );

   // Clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // One request: optional idle gap, then hold valid until accepted
   task automatic send_req(input logic [OP_W-1:0] op, input logic [3:0] a,
                           input logic [3:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.address    <= a;
      req_ch.write_data <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      case (op)
         OP_READ:  n_read++;
         OP_WRITE: n_write++;
         OP_TICK:  n_tick++;
         default:  n_unused++;
      endcase
   endtask

   task automatic write_reg(input logic [3:0] a, input logic [3:0] d);
      send_req(OP_WRITE, a, d);
   endtask

   task automatic read_reg(input logic [3:0] a);
      send_req(OP_READ, a, 4'($urandom_range(0, 15)));
   endtask

   task automatic tick_once();
      send_req(OP_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   // Digit write that now and then puts a non-BCD or arbitrary value instead
   task automatic write_digit(input logic [3:0] a, input int v);
      if ($urandom_range(0, 9) == 0) write_reg(a, 4'($urandom_range(0, 15)));
      else write_reg(a, 4'(v));
   endtask

   // Hold the sender until every outstanding result is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Park the time and date just before a rollover, then send ticks that may carry through it
   task automatic rollover_sequence();
      logic       h24, pm, stay_stopped;
      logic [1:0] leap;
      int         pick, month, last_day, hour, n;
      h24  = 1'($urandom_range(0, 1));
      pm   = 1'($urandom_range(0, 1));
      leap = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 15);
      month = (pick < 12) ? pick + 1 : ((pick == 12) ? 0 : pick);
      case (month)
         2:            last_day = (leap == 2'd0) ? 29 - $urandom_range(0, 1) : 28;
         4, 6, 9, 11:  last_day = 30;
         default:      last_day = 31;
      endcase
      if ($urandom_range(0, 3) == 0) last_day = $urandom_range(1, 31);
      hour = h24 ? 23 : 11 + $urandom_range(0, 1);
      stay_stopped = ($urandom_range(0, 7) == 0);
      // Stop the clock, which also clears tenths
      write_reg(ADDR_STATUS, {1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'($urandom_range(0, 1))});
      write_reg(ADDR_SETTING, {leap, pm, h24});
      write_digit(ADDR_SEC_U, 9);
      write_digit(ADDR_SEC_T, 5);
      write_digit(ADDR_MIN_U, 9);
      write_digit(ADDR_MIN_T, 5);
      write_digit(ADDR_HR_U, hour % 10);
      write_digit(ADDR_HR_T, hour / 10);
      write_digit(ADDR_DAY_U, last_day % 10);
      write_digit(ADDR_DAY_T, last_day / 10);
      write_digit(ADDR_MON_U, month % 10);
      write_digit(ADDR_MON_T, month / 10);
      write_digit(ADDR_YR_U, ($urandom_range(0, 1)) ? 9 : $urandom_range(0, 9));
      write_digit(ADDR_YR_T, ($urandom_range(0, 1)) ? 9 : $urandom_range(0, 9));
      write_digit(ADDR_WDAY, $urandom_range(1, 7));
      write_reg(ADDR_STATUS, {1'($urandom_range(0, 1)), stay_stopped,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))});
      n = $urandom_range(8, 14);
      repeat (n) begin
         tick_once();
         if ($urandom_range(0, 4) == 0) read_reg(4'($urandom_range(0, 15)));
      end
      repeat (3) read_reg(4'($urandom_range(0, 15)));
   endtask

   // Program the interval timer and tick past its delay, or as far as the phase budget allows
   task automatic timer_sequence(input int budget);
      logic       rep, stop, hold;
      logic [2:0] code;
      int         pick, delay, n;
      pick = $urandom_range(0, 19);
      if (pick < 2) code = 3'd0;
      else if (pick < 17) code = 3'($urandom_range(1, 4));
      else if (pick < 19) code = 3'($urandom_range(5, 6));
      else code = 3'd7;
      case (code)
         3'd1:    delay = 1;
         3'd2:    delay = 5;
         3'd3:    delay = 10;
         3'd4:    delay = 50;
         3'd5:    delay = 100;
         3'd6:    delay = 300;
         3'd7:    delay = 600;
         default: delay = 4;
      endcase
      rep  = 1'($urandom_range(0, 1));
      stop = ($urandom_range(0, 3) == 0);
      hold = 1'($urandom_range(0, 1));
      write_reg(ADDR_STATUS, {1'($urandom_range(0, 1)), stop, 1'b1, hold});
      write_reg(ADDR_SETTING, {rep, code});
      // Release the hold so the timer arms on the falling edge of the bit
      if (hold || $urandom_range(0, 3) == 0) begin
         write_reg(ADDR_STATUS, {1'($urandom_range(0, 1)), stop, 1'($urandom_range(0, 1)), 1'b0});
      end
      n = (delay >= 100) ? delay + $urandom_range(1, 3) : 2 * delay + $urandom_range(0, 3);
      if (n > budget) n = (budget > 0) ? budget : 1;
      repeat (n) begin
         tick_once();
         if ($urandom_range(0, 7) == 0) read_reg(ADDR_STATUS);
         if ($urandom_range(0, 59) == 0) write_reg(ADDR_STATUS, 4'($urandom_range(0, 15)));
      end
      read_reg(ADDR_STATUS);
   endtask

   // Unstructured requests, unused operation code included
   task automatic noise_burst();
      int n;
      n = $urandom_range(3, 10);
      repeat (n) begin
         send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
      end
   endtask

   task automatic random_phase(input int idle_pct, input int stall);
      int goal, pick;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      goal = n_read + n_write + n_tick + PHASE_ITEMS;
      while (n_read + n_write + n_tick < goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) rollover_sequence();
         else if (pick < 7) timer_sequence(goal - (n_read + n_write + n_tick));
         else if (pick < 9) noise_burst();
         else repeat (4) read_reg(4'($urandom_range(0, 15)));
      end
      wait_drained();
   endtask

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_READ;
      req_ch.address    <= ADDR_STATUS;
      req_ch.write_data <= 4'd0;
      reset             <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset values, unused code, read-only tenths, stop, timer, 12-hour PM
      read_reg(ADDR_STATUS);
      read_reg(ADDR_SETTING);
      read_reg(ADDR_WDAY);
      send_req(OP_UNUSED, 4'hF, 4'hF);
      write_reg(ADDR_TENTHS, 4'hF);
      tick_once();
      read_reg(ADDR_TENTHS);
      read_reg(ADDR_STATUS);
      write_reg(ADDR_STATUS, 4'h4);
      tick_once();
      read_reg(ADDR_TENTHS);
      write_reg(ADDR_STATUS, 4'h2);
      write_reg(ADDR_SETTING, 4'h1);
      tick_once();
      read_reg(ADDR_STATUS);
      write_reg(ADDR_SETTING, 4'h8);
      write_reg(ADDR_STATUS, 4'h3);
      write_reg(ADDR_STATUS, 4'h0);
      write_reg(ADDR_SETTING, 4'hE);
      read_reg(ADDR_SETTING);
      write_reg(ADDR_HR_T, 4'hF);
      read_reg(ADDR_HR_T);
      write_reg(ADDR_YR_T, 4'hF);
      read_reg(ADDR_YR_T);
      wait_drained();

      random_phase(0, 0);
      random_phase(49, 0);
      random_phase(0, 49);
      random_phase(26, 26);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d reads, %0d writes, %0d ticks and %0d unused-code requests",
               n_read, n_write, n_tick, n_unused);
      $display("Checked %0d results across four flow-control phases, %0d with interrupt set",
               checked_count, irq_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
